### hdl/hvsi_pkg.sv
`timescale 1ns / 1ps

package hvsi_pkg;

  // table geometry (power of two, 4 to 65536)
  localparam int TABLE_SIZE = 65536;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int ID_W       = 64;

  // most entries held at once: one slot always stays empty
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_SIZE - 1);

  // golden-ratio multiplier, split into 32-bit halves
  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
  localparam logic [31:0] MULT_LO   = HASH_MULT[31:0];
  localparam logic [31:0] MULT_HI   = HASH_MULT[63:32];

  // hash takes the top 16 bits of the 64-bit product
  localparam int HASH_BITS = 16;
  localparam int HASH_LSB  = 32 - HASH_BITS;

endpackage

### hdl/hash_visited_set_insert_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake               | payload
// in      | into      | in_valid / in_stall     | entry_id[63:0], id_known
// out     | out of    | out_valid / out_stall   | already_seen, inserted, table_full
//
// an item with a readable non-zero id is taken, hashed on one shared 32x32 multiplier, read
// from the table at its hash slot, probed slot by slot on the single read port, and then its
// result is handed to the output register. an unreadable or zero id is taken and goes
// straight to the hand-off. one item is in work at a time.
// after reset a clearing pass writes zero to all TABLE_SIZE slots,
// with in_stall held high throughout.
// a stalled output holds its beat; the next item is taken meanwhile and waits at the end.

module hash_visited_set_insert_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [hvsi_pkg::ID_W-1:0] entry_id,
  input  logic                   id_known,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   already_seen,
  output logic                   inserted,
  output logic                   table_full
);

  import hvsi_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [ADDR_W-1:0] LAST_SLOT = {ADDR_W{1'b1}};

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        hash_step;
  logic [ID_W-1:0]   id_reg;
  logic [31:0]       acc;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] probe_cnt;
  logic [CNT_W-1:0]  fill_count;
  logic              pend_seen;
  logic              pend_ins;
  logic              pend_full;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [31:0]       acc_sum;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ID_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ID_W-1:0]   mem_rdata;

  logic              in_take;
  logic              out_free;
  logic              slot_hit;
  logic              slot_empty;
  logic              do_insert;

  logic [ID_W-1:0]   id_table [TABLE_SIZE];

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // shared multiplier: low x low, high x low, low x high
  always_comb begin
    unique case (hash_step)
      2'd0:    begin mul_a = id_reg[31:0];  mul_b = MULT_LO; end
      2'd1:    begin mul_a = id_reg[63:32]; mul_b = MULT_LO; end
      default: begin mul_a = id_reg[31:0];  mul_b = MULT_HI; end
    endcase
  end

  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign acc_sum = acc + mul_p[31:0];

  // probe compare
  assign slot_hit   = (mem_rdata == id_reg);
  assign slot_empty = (mem_rdata == '0);
  assign do_insert  = (state == S_CMP) && !slot_hit && slot_empty && (fill_count < FILL_MAX);

  // memory ports: clearing pass or insert on write, probe on read
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = id_reg;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (do_insert) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state == S_CMP) ? slot + 1'b1 : slot;
  end

  // id table, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_table[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= id_table[mem_raddr];
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      hash_step  <= '0;
      fill_count <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            hash_step <= '0;
            if (!id_known || entry_id == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          hash_step <= hash_step + 1'b1;
          if (hash_step == 2'd2) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (slot_hit || slot_empty || probe_cnt == LAST_SLOT) begin
            state <= S_DONE;
          end
          if (do_insert) begin
            fill_count <= fill_count + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item datapath: id capture, hash accumulate, probe walk, pending result
  always_ff @(posedge clk) begin
    if (in_take) begin
      id_reg    <= entry_id;
      pend_seen <= 1'b0;
      pend_ins  <= 1'b0;
      pend_full <= 1'b0;
    end
    if (state == S_HASH) begin
      unique case (hash_step)
        2'd0:    acc <= mul_p[63:32];
        2'd1:    acc <= acc_sum;
        default: begin
          slot      <= acc_sum[HASH_LSB +: ADDR_W];
          probe_cnt <= '0;
        end
      endcase
    end
    if (state == S_CMP) begin
      if (slot_hit) begin
        pend_seen <= 1'b1;
      end else if (slot_empty) begin
        pend_ins  <= do_insert;
        pend_full <= !do_insert;
      end else if (probe_cnt == LAST_SLOT) begin
        pend_full <= 1'b1;
      end else begin
        slot      <= slot + 1'b1;
        probe_cnt <= probe_cnt + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      already_seen <= pend_seen;
      inserted     <= pend_ins;
      table_full   <= pend_full;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_MAX)
    else $error("fill count above limit");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({already_seen, inserted, table_full}))
    else $error("more than one outcome flag set");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> fill_count == $past(fill_count) + 1'b1)
    else $error("fill count did not follow insert");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_HASH || state == S_DONE) |-> !mem_we)
    else $error("table written outside clear or probe");

  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    do_insert |-> (mem_rdata == '0) && (id_reg != '0))
    else $error("insert over an occupied slot or of zero id");

endmodule
